[sv/bump_and_go_avoidance_fsm_assert.svh]
// Assertion macros for the bump-and-go avoidance controller.
`ifndef BUMP_AND_GO_AVOIDANCE_FSM_ASSERT_SVH
`define BUMP_AND_GO_AVOIDANCE_FSM_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BAG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bag assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BAG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bag assertion failed");

`endif

[sv/bag_pkg.sv]
// Package: widths, limits, codes and shared types of the avoidance controller.
`timescale 1ns / 1ps
package bag_pkg;

   localparam int MAX_SAMPLES     = 1024;
   localparam int MAX_HALF_WINDOW = 256;

   localparam int RANGE_W    = 16;
   localparam int SUM_W      = 24;
   localparam int SPEED_W    = 15;
   localparam int VEL_W      = 16;
   localparam int TICK_W     = 16;
   localparam int CENTER_W   = 10;
   localparam int HALF_W     = 9;
   localparam int STATE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Sample counter holds MAX_SAMPLES itself.
   localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DIST_W  = ((COUNT_W > CENTER_W) ? COUNT_W : CENTER_W) + 2;

   localparam logic [RANGE_W-1:0] NO_RETURN = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      MODE_FWD  = 2'd0,
      MODE_BACK = 2'd1,
      MODE_TURN = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_LEFT  = 2'd1,
      SIDE_RIGHT = 2'd2
   } side_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_LINEAR  = 3'd0,
      CSR_SPEED_ANGULAR = 3'd1,
      CSR_OBSTACLE_DIST = 3'd2,
      CSR_SCAN_TIMEOUT  = 3'd3,
      CSR_BACKING_TICKS = 3'd4,
      CSR_TURNING_TICKS = 3'd5,
      CSR_CENTER_INDEX  = 3'd6,
      CSR_WINDOW_HALF   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_min;
      logic [SUM_W-1:0]   range_sum;
      logic               no_return;
   } win_stat_type;

endpackage

[sv/bag_ifs.sv]
// Interfaces: sample/tick request, velocity response and register write channels.
`timescale 1ns / 1ps
interface bag_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [bag_pkg::RANGE_W-1:0] range_mm;
   logic                        last_sample;
   modport source (output valid, output op, output range_mm, output last_sample,
                   input ready);
   modport sink   (input valid, input op, input range_mm, input last_sample,
                   output ready);
endinterface

interface bag_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bag_pkg::VEL_W-1:0]   linear_velocity;
   logic signed [bag_pkg::VEL_W-1:0]   angular_velocity;
   logic        [bag_pkg::STATE_W-1:0] motion_state;
   modport source (output valid, output linear_velocity, output angular_velocity,
                   output motion_state, input ready);
   modport sink   (input valid, input linear_velocity, input angular_velocity,
                   input motion_state, output ready);
endinterface

interface bag_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bag_pkg::CSR_IDX_W-1:0]  index;
   logic [bag_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/bag_window.sv]
// Side window accumulator: running minimum, saturating sum and no-return mark.
`timescale 1ns / 1ps
module bag_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic                        clear,
   input  logic [bag_pkg::RANGE_W-1:0] range_mm,
   output bag_pkg::win_stat_type       stat_now
);

   bag_pkg::win_stat_type     stat_ff;
   bag_pkg::win_stat_type     stat_in;
   logic [bag_pkg::SUM_W:0]   sum_wide;

   assign sum_wide = {1'b0, stat_ff.range_sum} + (bag_pkg::SUM_W + 1)'(range_mm);

   // Value after this beat's sample, before any scan-end clear.
   always_comb begin
      stat_now = stat_ff;
      if (take) begin
         if (range_mm == bag_pkg::NO_RETURN) begin
            stat_now.no_return = 1'b1;
         end else begin
            if (range_mm < stat_ff.range_min) begin
               stat_now.range_min = range_mm;
            end
            stat_now.range_sum = sum_wide[bag_pkg::SUM_W] ? bag_pkg::SUM_MAX
                                                          : sum_wide[bag_pkg::SUM_W-1:0];
         end
      end
   end

   always_comb begin
      stat_in = stat_now;
      if (clear) begin
         stat_in.range_min = bag_pkg::NO_RETURN;
         stat_in.range_sum = '0;
         stat_in.no_return = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff.range_min <= bag_pkg::NO_RETURN;
         stat_ff.range_sum <= '0;
         stat_ff.no_return <= 1'b0;
      end else begin
         stat_ff <= stat_in;
      end
   end

endmodule

[sv/bump_and_go_avoidance_fsm.sv]
// Top level: bump-and-go obstacle avoidance controller.
// Pipeline: a beat is registered at the input and processed from there; a tick's
//   velocity beat is loaded into the rsp register when that register is free, and
//   the input register holds the tick while rsp is full and stalled.
// Throughput: one req beat per cycle; only a tick waiting on a full, stalled rsp
//   register holds req back.
// Reset: synchronous, active high; registers return to their defaults, mode forward.
`timescale 1ns / 1ps
module bump_and_go_avoidance_fsm (
   input  logic      clock,
   input  logic      reset,
   bag_req_if.sink   req_if,
   bag_rsp_if.source rsp_if,
   bag_csr_if.sink   csr_if
);

   `include "bump_and_go_avoidance_fsm_assert.svh"

   // ---------------------------------------------------------------------------
   // Configuration registers. The user must write only while the block is idle; the block does not enforce it.
   // ---------------------------------------------------------------------------
   logic [bag_pkg::SPEED_W-1:0]  speed_linear_ff;
   logic [bag_pkg::SPEED_W-1:0]  speed_angular_ff;
   logic [bag_pkg::RANGE_W-1:0]  obstacle_dist_ff;
   logic [bag_pkg::TICK_W-1:0]   scan_timeout_ff;
   logic [bag_pkg::TICK_W-1:0]   backing_ticks_ff;
   logic [bag_pkg::TICK_W-1:0]   turning_ticks_ff;
   logic [bag_pkg::CENTER_W-1:0] center_ff;
   logic [bag_pkg::HALF_W-1:0]   half_ff;
   logic                         csr_write;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_linear_ff  <= bag_pkg::SPEED_W'(300);
         speed_angular_ff <= bag_pkg::SPEED_W'(300);
         obstacle_dist_ff <= bag_pkg::RANGE_W'(1000);
         scan_timeout_ff  <= bag_pkg::TICK_W'(20);
         backing_ticks_ff <= bag_pkg::TICK_W'(40);
         turning_ticks_ff <= bag_pkg::TICK_W'(40);
         center_ff        <= bag_pkg::CENTER_W'(512);
         half_ff          <= bag_pkg::HALF_W'(64);
      end else if (csr_write) begin
         case (bag_pkg::csr_index_type'(csr_if.index))
            bag_pkg::CSR_SPEED_LINEAR:  speed_linear_ff  <= csr_if.data[bag_pkg::SPEED_W-1:0];
            bag_pkg::CSR_SPEED_ANGULAR: speed_angular_ff <= csr_if.data[bag_pkg::SPEED_W-1:0];
            bag_pkg::CSR_OBSTACLE_DIST: obstacle_dist_ff <= csr_if.data[bag_pkg::RANGE_W-1:0];
            bag_pkg::CSR_SCAN_TIMEOUT:  scan_timeout_ff  <= csr_if.data[bag_pkg::TICK_W-1:0];
            bag_pkg::CSR_BACKING_TICKS: backing_ticks_ff <= csr_if.data[bag_pkg::TICK_W-1:0];
            bag_pkg::CSR_TURNING_TICKS: turning_ticks_ff <= csr_if.data[bag_pkg::TICK_W-1:0];
            bag_pkg::CSR_CENTER_INDEX:  center_ff        <= csr_if.data[bag_pkg::CENTER_W-1:0];
            bag_pkg::CSR_WINDOW_HALF:   half_ff          <= csr_if.data[bag_pkg::HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Input register. A held beat advances when it makes no result, or when the
   // result register is free (empty or being drained this cycle).
   // ---------------------------------------------------------------------------
   logic                        in_valid_ff;
   logic                        in_op_ff;
   logic [bag_pkg::RANGE_W-1:0] in_range_ff;
   logic                        in_last_ff;
   logic                        rsp_valid_ff;
   logic                        scan_seen_ff;
   logic                        out_free;
   logic                        makes_result;
   logic                        advance;
   logic                        req_take;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign makes_result = (in_op_ff == bag_pkg::OP_TICK) && scan_seen_ff;
   assign advance      = in_valid_ff && (!makes_result || out_free);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= req_if.op;
         in_range_ff <= req_if.range_mm;
         in_last_ff  <= req_if.last_sample;
      end
   end

   // ---------------------------------------------------------------------------
   // Scan path: place the sample in a side window, fold it in, latch at scan end.
   // ---------------------------------------------------------------------------
   logic                         sample_go;
   logic                         scan_end;
   logic [bag_pkg::COUNT_W-1:0]  count_ff;
   logic [bag_pkg::COUNT_W-1:0]  count_in;
   logic                         count_open;
   logic [bag_pkg::DIST_W-1:0]   idx;
   logic [bag_pkg::DIST_W-1:0]   ctr;
   logic [bag_pkg::DIST_W-1:0]   half_eff;
   logic                         hit_left;
   logic                         hit_right;
   bag_pkg::win_stat_type        left_now;
   bag_pkg::win_stat_type        right_now;
   logic                         near_ff;
   logic                         near_in;
   bag_pkg::side_type            side_ff;
   bag_pkg::side_type            side_in;

   assign sample_go  = advance && (in_op_ff == bag_pkg::OP_SAMPLE);
   assign scan_end   = sample_go && in_last_ff;
   assign count_open = count_ff < bag_pkg::COUNT_W'(bag_pkg::MAX_SAMPLES);

   assign idx      = bag_pkg::DIST_W'(count_ff);
   assign ctr      = bag_pkg::DIST_W'(center_ff);
   // Clamp oversized half windows to the supported maximum.
   assign half_eff = (bag_pkg::DIST_W'(half_ff) > bag_pkg::DIST_W'(bag_pkg::MAX_HALF_WINDOW))
                     ? bag_pkg::DIST_W'(bag_pkg::MAX_HALF_WINDOW)
                     : bag_pkg::DIST_W'(half_ff);

   // Left lies above center, right below; the center sample itself is in neither.
   assign hit_left  = sample_go && count_open && (idx > ctr) && ((idx - ctr) <= half_eff);
   assign hit_right = sample_go && count_open && (idx < ctr) && ((ctr - idx) <= half_eff);

   bag_window u_left (
      .clock    (clock),
      .reset    (reset),
      .take     (hit_left),
      .clear    (scan_end),
      .range_mm (in_range_ff),
      .stat_now (left_now)
   );

   bag_window u_right (
      .clock    (clock),
      .reset    (reset),
      .take     (hit_right),
      .clear    (scan_end),
      .range_mm (in_range_ff),
      .stat_now (right_now)
   );

   always_comb begin
      count_in = count_ff;
      if (scan_end) begin
         count_in = '0;
      end else if (sample_go && count_open) begin
         count_in = count_ff + bag_pkg::COUNT_W'(1);
      end
   end

   // Scan-end latch uses window values that already include the closing sample.
   always_comb begin
      near_in = near_ff;
      side_in = side_ff;
      if (scan_end) begin
         near_in = ((left_now.range_min != bag_pkg::NO_RETURN) &&
                    (left_now.range_min <= obstacle_dist_ff)) ||
                   ((right_now.range_min != bag_pkg::NO_RETURN) &&
                    (right_now.range_min <= obstacle_dist_ff));
         side_in = bag_pkg::SIDE_NONE;
         if (!left_now.no_return && !right_now.no_return) begin
            if (left_now.range_sum < right_now.range_sum) begin
               side_in = bag_pkg::SIDE_LEFT;
            end else if (right_now.range_sum < left_now.range_sum) begin
               side_in = bag_pkg::SIDE_RIGHT;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tick path: saturating timers and the forward/back/turn/stop machine.
   // ---------------------------------------------------------------------------
   logic                       tick_go;
   logic                       scan_seen_in;
   logic [bag_pkg::TICK_W-1:0] scan_age_ff;
   logic [bag_pkg::TICK_W-1:0] scan_age_in;
   logic [bag_pkg::TICK_W-1:0] age_inc;
   logic [bag_pkg::TICK_W-1:0] mode_ticks_ff;
   logic [bag_pkg::TICK_W-1:0] mode_ticks_in;
   logic [bag_pkg::TICK_W-1:0] ticks_inc;
   bag_pkg::mode_type          mode_ff;
   bag_pkg::mode_type          mode_in;
   logic                       turn_left_ff;
   logic                       turn_left_in;
   logic                       turn_right_ff;
   logic                       turn_right_in;
   logic                       flags_clear;
   logic                       turn_left_eff;
   logic                       turn_right_eff;

   assign tick_go      = advance && makes_result;
   assign scan_seen_in = scan_seen_ff || scan_end;
   assign age_inc      = (scan_age_ff == '1) ? scan_age_ff
                                             : scan_age_ff + bag_pkg::TICK_W'(1);
   assign ticks_inc    = (mode_ticks_ff == '1) ? mode_ticks_ff
                                               : mode_ticks_ff + bag_pkg::TICK_W'(1);

   always_comb begin
      scan_age_in = scan_age_ff;
      if (scan_end) begin
         scan_age_in = '0;
      end else if (tick_go) begin
         scan_age_in = age_inc;
      end
   end

   // Pick a turn side once per turn: the side with the smaller sum is closer,
   // so steer away from it.
   assign flags_clear    = !turn_left_ff && !turn_right_ff;
   assign turn_left_eff  = turn_left_ff || (flags_clear && (side_ff == bag_pkg::SIDE_RIGHT));
   assign turn_right_eff = turn_right_ff || (flags_clear && (side_ff == bag_pkg::SIDE_LEFT));

   // Next state. Timers are bumped first, then tested with strict compares.
   always_comb begin
      mode_in       = mode_ff;
      mode_ticks_in = mode_ticks_ff;
      turn_left_in  = turn_left_ff;
      turn_right_in = turn_right_ff;
      if (tick_go) begin
         mode_ticks_in = ticks_inc;
         case (mode_ff)
            bag_pkg::MODE_FWD: begin
               if (near_ff) begin
                  mode_in       = bag_pkg::MODE_BACK;
                  mode_ticks_in = '0;
               end else if (age_inc > scan_timeout_ff) begin
                  mode_in       = bag_pkg::MODE_STOP;
                  mode_ticks_in = '0;
               end
            end
            bag_pkg::MODE_BACK: begin
               if (ticks_inc > backing_ticks_ff) begin
                  mode_in       = bag_pkg::MODE_TURN;
                  mode_ticks_in = '0;
               end
            end
            bag_pkg::MODE_TURN: begin
               turn_left_in  = turn_left_eff;
               turn_right_in = turn_right_eff;
               if (ticks_inc > turning_ticks_ff) begin
                  turn_left_in  = 1'b0;
                  turn_right_in = 1'b0;
                  mode_in       = bag_pkg::MODE_FWD;
                  mode_ticks_in = '0;
               end
            end
            bag_pkg::MODE_STOP: begin
               if (age_inc < scan_timeout_ff) begin
                  mode_in       = bag_pkg::MODE_FWD;
                  mode_ticks_in = '0;
               end
            end
            default: begin
               mode_in       = bag_pkg::MODE_STOP;
               mode_ticks_in = '0;
            end
         endcase
      end
   end

   // Outputs of the machine: command for the mode held at this tick.
   logic [bag_pkg::VEL_W-1:0] lin_cmd;
   logic [bag_pkg::VEL_W-1:0] ang_cmd;

   always_comb begin
      lin_cmd = '0;
      ang_cmd = '0;
      case (mode_ff)
         bag_pkg::MODE_FWD:  lin_cmd = bag_pkg::VEL_W'(speed_linear_ff);
         bag_pkg::MODE_BACK: lin_cmd = bag_pkg::VEL_W'(0) - bag_pkg::VEL_W'(speed_linear_ff);
         bag_pkg::MODE_TURN: begin
            if (turn_left_eff) begin
               ang_cmd = bag_pkg::VEL_W'(speed_angular_ff);
            end else if (turn_right_eff) begin
               ang_cmd = bag_pkg::VEL_W'(0) - bag_pkg::VEL_W'(speed_angular_ff);
            end
         end
         bag_pkg::MODE_STOP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         near_ff       <= 1'b0;
         side_ff       <= bag_pkg::SIDE_NONE;
         scan_seen_ff  <= 1'b0;
         scan_age_ff   <= '0;
         mode_ff       <= bag_pkg::MODE_FWD;
         mode_ticks_ff <= '0;
         turn_left_ff  <= 1'b0;
         turn_right_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         near_ff       <= near_in;
         side_ff       <= side_in;
         scan_seen_ff  <= scan_seen_in;
         scan_age_ff   <= scan_age_in;
         mode_ff       <= mode_in;
         mode_ticks_ff <= mode_ticks_in;
         turn_left_ff  <= turn_left_in;
         turn_right_ff <= turn_right_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register: load on a processed tick, drop when the beat is taken.
   // ---------------------------------------------------------------------------
   logic                        rsp_load;
   logic [bag_pkg::VEL_W-1:0]   rsp_lin_ff;
   logic [bag_pkg::VEL_W-1:0]   rsp_ang_ff;
   logic [bag_pkg::STATE_W-1:0] rsp_state_ff;

   assign rsp_load = tick_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_lin_ff   <= lin_cmd;
         rsp_ang_ff   <= ang_cmd;
         rsp_state_ff <= mode_ff;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.linear_velocity  = rsp_lin_ff;
   assign rsp_if.angular_velocity = rsp_ang_ff;
   assign rsp_if.motion_state     = rsp_state_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `BAG_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_if.ready, !rsp_load)
   `BAG_ASSERT_NOW(a_result_after_scan, rsp_load, scan_seen_ff)
   `BAG_ASSERT_NOW(a_flags_only_turning, turn_left_ff || turn_right_ff, (mode_ff == bag_pkg::MODE_TURN) && !(turn_left_ff && turn_right_ff))
   `BAG_ASSERT_NEXT(a_scan_end_resets_age, scan_end, (scan_age_ff == '0) && (count_ff == '0))

endmodule

[sim/tb_top.sv]
// Testbench: drives samples and ticks, predicts each velocity command and checks it.
`timescale 1ns / 1ps

import bag_pkg::*;

typedef struct {
   logic signed [VEL_W-1:0] lin_vel;
   logic signed [VEL_W-1:0] ang_vel;
   mode_type                state;
} velocity_cmd_type;

class velocity_scoreboard;
   logic [SPEED_W-1:0]  speed_lin;
   logic [SPEED_W-1:0]  speed_ang;
   logic [RANGE_W-1:0]  near_dist;
   logic [TICK_W-1:0]   age_limit;
   logic [TICK_W-1:0]   back_limit;
   logic [TICK_W-1:0]   turn_limit;
   logic [CENTER_W-1:0] center;
   logic [HALF_W-1:0]   half_cfg;

   mode_type            mode;
   logic [TICK_W-1:0]   mode_ticks;
   logic [TICK_W-1:0]   scan_age;
   bit                  scan_seen;
   int                  sample_idx;
   win_stat_type        left_win;
   win_stat_type        right_win;
   bit                  near_flag;
   side_type            closer;
   bit                  turn_left;
   bit                  turn_right;

   velocity_cmd_type    command_queue[$];
   int                  errors;

   function new();
      speed_lin  = 15'd300;
      speed_ang  = 15'd300;
      near_dist  = 16'd1000;
      age_limit  = 16'd20;
      back_limit = 16'd40;
      turn_limit = 16'd40;
      center     = 10'd512;
      half_cfg   = 9'd64;
      mode       = MODE_FWD;
      mode_ticks = '0;
      scan_age   = '0;
      scan_seen  = 1'b0;
      near_flag  = 1'b0;
      closer     = SIDE_NONE;
      turn_left  = 1'b0;
      turn_right = 1'b0;
      errors     = 0;
      clear_windows();
   endfunction

   function void clear_windows();
      sample_idx = 0;
      left_win   = '{NO_RETURN, {SUM_W{1'b0}}, 1'b0};
      right_win  = '{NO_RETURN, {SUM_W{1'b0}}, 1'b0};
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SPEED_LINEAR:  speed_lin  = data[SPEED_W-1:0];
         CSR_SPEED_ANGULAR: speed_ang  = data[SPEED_W-1:0];
         CSR_OBSTACLE_DIST: near_dist  = data[RANGE_W-1:0];
         CSR_SCAN_TIMEOUT:  age_limit  = data[TICK_W-1:0];
         CSR_BACKING_TICKS: back_limit = data[TICK_W-1:0];
         CSR_TURNING_TICKS: turn_limit = data[TICK_W-1:0];
         CSR_CENTER_INDEX:  center     = data[CENTER_W-1:0];
         CSR_WINDOW_HALF:   half_cfg   = data[HALF_W-1:0];
         default: ;
      endcase
   endfunction

   // No-return samples only mark the window; others fold into min and a saturating sum.
   function win_stat_type accumulate(win_stat_type w, logic [RANGE_W-1:0] r);
      logic [SUM_W:0] total;
      if (r == NO_RETURN) begin
         w.no_return = 1'b1;
         return w;
      end
      if (r < w.range_min) w.range_min = r;
      total = {1'b0, w.range_sum} + r;
      w.range_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
      return w;
   endfunction

   function logic [TICK_W-1:0] bump(logic [TICK_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function void enter_mode(mode_type m);
      mode       = m;
      mode_ticks = '0;
   endfunction

   function void take_request(op_type op, logic [RANGE_W-1:0] rng, logic last);
      int               half_eff;
      int               ctr;
      velocity_cmd_type cmd;
      half_eff = (half_cfg > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(half_cfg);
      ctr      = int'(center);
      if (op == OP_SAMPLE) begin
         if (sample_idx < MAX_SAMPLES) begin
            if (sample_idx > ctr && sample_idx - ctr <= half_eff)
               left_win = accumulate(left_win, rng);
            else if (sample_idx < ctr && ctr - sample_idx <= half_eff)
               right_win = accumulate(right_win, rng);
            sample_idx++;
         end
         if (last) begin
            near_flag = (left_win.range_min != NO_RETURN && left_win.range_min <= near_dist) ||
                        (right_win.range_min != NO_RETURN && right_win.range_min <= near_dist);
            closer = SIDE_NONE;
            if (!left_win.no_return && !right_win.no_return) begin
               if (left_win.range_sum < right_win.range_sum)
                  closer = SIDE_LEFT;
               else if (right_win.range_sum < left_win.range_sum)
                  closer = SIDE_RIGHT;
            end
            clear_windows();
            scan_seen = 1'b1;
            scan_age  = '0;
         end
         return;
      end
      if (!scan_seen) return;

      scan_age    = bump(scan_age);
      mode_ticks  = bump(mode_ticks);
      cmd.lin_vel = '0;
      cmd.ang_vel = '0;
      cmd.state   = mode;
      case (mode)
         MODE_FWD: begin
            cmd.lin_vel = VEL_W'(speed_lin);
            if (scan_age > age_limit) enter_mode(MODE_STOP);
            if (near_flag) enter_mode(MODE_BACK);
         end
         MODE_BACK: begin
            cmd.lin_vel = -VEL_W'(speed_lin);
            if (mode_ticks > back_limit) enter_mode(MODE_TURN);
         end
         MODE_TURN: begin
            if (!turn_left && !turn_right) begin
               if (closer == SIDE_LEFT)
                  turn_right = 1'b1;
               else if (closer == SIDE_RIGHT)
                  turn_left = 1'b1;
            end
            if (turn_left)
               cmd.ang_vel = VEL_W'(speed_ang);
            else if (turn_right)
               cmd.ang_vel = -VEL_W'(speed_ang);
            if (mode_ticks > turn_limit) begin
               turn_left  = 1'b0;
               turn_right = 1'b0;
               enter_mode(MODE_FWD);
            end
         end
         default: begin
            if (scan_age < age_limit) enter_mode(MODE_FWD);
         end
      endcase
      command_queue.push_back(cmd);
   endfunction

   task flag_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_command(logic signed [VEL_W-1:0] lin, logic signed [VEL_W-1:0] ang,
                      logic [STATE_W-1:0] st);
      velocity_cmd_type want;
      if (command_queue.size() == 0) begin
         flag_mismatch($sformatf("command lin %0d ang %0d state %0d with none outstanding",
                                 lin, ang, st));
         return;
      end
      want = command_queue.pop_front();
      if (lin !== want.lin_vel)
         flag_mismatch($sformatf("linear_velocity got %0d want %0d", lin, want.lin_vel));
      if (ang !== want.ang_vel)
         flag_mismatch($sformatf("angular_velocity got %0d want %0d", ang, want.ang_vel));
      if (st !== want.state)
         flag_mismatch($sformatf("motion_state got %0d want %s", st, want.state.name()));
   endtask
endclass

module tb_top;
   localparam int TARGET_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 200000;
   // A tick beat passes the input and result registers before rsp can take it; allow margin.
   localparam int DRAIN_CYCLES = 6;

   logic                  clock = 1'b0;
   logic                  reset;
   int                    idle_pct   = 6;
   int                    items_sent = 0;
   int                    cycles     = 0;
   int                    phase;
   logic [CSR_DATA_W-1:0] cfg_image [8];
   logic [RANGE_W-1:0]    ranges[$];
   velocity_scoreboard    sb = new();

   bag_req_if req ();
   bag_rsp_if rsp ();
   bag_csr_if csr ();

   bump_and_go_avoidance_fsm DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   always #2 clock = ~clock;

   // Free-running cycle count; end the run if it never drains.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Velocity sink: check the beat seen at this edge, then roll the next ready.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_command(rsp.linear_velocity, rsp.angular_velocity, rsp.motion_state);
      rsp.ready <= ($urandom_range(99) >= idle_pct);
   end

   // Offer one request beat, with random idle cycles ahead of it. Valid stays high
   // after acceptance so back-to-back beats need no extra assignment.
   task automatic send_beat(op_type op, logic [RANGE_W-1:0] rng, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.op          <= op;
      req.range_mm    <= rng;
      req.last_sample <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      // Ticks before the first scan are ignored by the block; do not count them.
      if (op == OP_SAMPLE || sb.scan_seen) items_sent++;
      sb.take_request(op, rng, last);
   endtask

   // Stream one scan; the final sample carries the last flag.
   task automatic send_samples(logic [RANGE_W-1:0] scan[$]);
      foreach (scan[k])
         send_beat(OP_SAMPLE, scan[k], k == scan.size() - 1);
   endtask

   task automatic send_ticks(int count);
      repeat (count) send_beat(OP_TICK, RANGE_W'($urandom), 1'($urandom));
   endtask

   // Drop valid, hold until every command came back, then let the pipe settle.
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (sb.command_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write every register from cfg_image; only called with the block idle.
   task automatic program_registers();
      for (int k = 0; k < $size(cfg_image); k++) begin
         csr.valid <= 1'b1;
         csr.index <= csr_index_type'(k);
         csr.data  <= cfg_image[k];
         @(posedge clock);
         while (!csr.ready) @(posedge clock);
         sb.write_reg(csr_index_type'(k), cfg_image[k]);
      end
      csr.valid <= 1'b0;
   endtask

   // Mostly small values so modes cycle; extremes and masked upper bits now and then.
   function automatic logic [CSR_DATA_W-1:0] pick_value(logic [CSR_DATA_W-1:0] top,
                                                      int unsigned small_hi);
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return top;
         3:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(1, small_hi));
      endcase
   endfunction

   // Range mix: no-return, both ends, plenty near the obstacle threshold.
   function automatic logic [RANGE_W-1:0] pick_range();
      int r;
      r = $urandom_range(49);
      if (r < 2) return NO_RETURN;
      if (r < 4) return '0;
      if (r < 6) return NO_RETURN - 1'b1;
      if (r < 20) return RANGE_W'($urandom_range(0, sb.near_dist));
      return RANGE_W'($urandom);
   endfunction

   // Long-scan settings put center at the top index and half beyond the clamp.
   function automatic void roll_config(bit long_scan);
      int c;
      int h;
      c = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 20);
      case ($urandom_range(5))
         0:       h = 0;
         1:       h = $urandom_range(300, 511);
         default: h = $urandom_range(1, 8);
      endcase
      cfg_image[CSR_SPEED_LINEAR]  = pick_value(16'h7FFF, 2000);
      cfg_image[CSR_SPEED_ANGULAR] = pick_value(16'h7FFF, 2000);
      cfg_image[CSR_OBSTACLE_DIST] = pick_value(16'hFFFF, 3000);
      cfg_image[CSR_SCAN_TIMEOUT]  = pick_value(16'hFFFF, 10);
      cfg_image[CSR_BACKING_TICKS] = pick_value(16'hFFFF, 5);
      cfg_image[CSR_TURNING_TICKS] = pick_value(16'hFFFF, 5);
      // Random upper bits beyond the field width are masked by the block.
      cfg_image[CSR_CENTER_INDEX]  = long_scan ? '1 :
                                     (CSR_DATA_W'($urandom) & 16'hFC00) | CSR_DATA_W'(c);
      cfg_image[CSR_WINDOW_HALF]   = long_scan ? '1 :
                                     (CSR_DATA_W'($urandom) & 16'hFE00) | CSR_DATA_W'(h);
   endfunction

   // One settings phase: mostly whole scans followed by ticks, some noise and tick
   // bursts. Halfway through, pause the sender until every command has come back.
   task automatic run_phase(bit long_scan, int budget);
      int                 stop_at;
      int                 mid;
      int                 pick;
      int                 len;
      int                 reach;
      bit                 paused;
      logic [RANGE_W-1:0] scan[$];
      stop_at = items_sent + budget;
      mid     = items_sent + budget / 2;
      paused  = 1'b0;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (long_scan || pick < 75) begin
            reach = sb.center + ((sb.half_cfg > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW
                                                                 : sb.half_cfg) + 1;
            // A long scan runs past the sample limit so the count saturates.
            if (long_scan)
               len = MAX_SAMPLES + $urandom_range(2, 9);
            else
               len = reach + $urandom_range(0, 3);
            if (!long_scan && len > 48) len = $urandom_range(24, 48);
            scan = {};
            repeat (len) scan.push_back(pick_range());
            send_samples(scan);
            send_ticks($urandom_range(0, 7));
            long_scan = 1'b0;
         end else if (pick < 90) begin
            // Noise: ticks mid-scan, stray last flags, scans cut short.
            repeat ($urandom_range(1, 6))
               send_beat(op_type'($urandom_range(1)), RANGE_W'($urandom), 1'($urandom));
         end else begin
            send_ticks($urandom_range(1, 9));
         end
         if (!paused && items_sent >= mid) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.op          = OP_SAMPLE;
      req.range_mm    = '0;
      req.last_sample = 1'b0;
      csr.valid       = 1'b0;
      csr.index       = CSR_SPEED_LINEAR;
      csr.data        = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed settings: full speeds, short timers, tiny windows around index 2
      // (right window is index 1, left window is index 3).
      cfg_image[CSR_SPEED_LINEAR]  = 16'h7FFF;
      cfg_image[CSR_SPEED_ANGULAR] = 16'h7FFF;
      cfg_image[CSR_OBSTACLE_DIST] = 16'd1000;
      cfg_image[CSR_SCAN_TIMEOUT]  = 16'd3;
      cfg_image[CSR_BACKING_TICKS] = 16'd1;
      cfg_image[CSR_TURNING_TICKS] = 16'd1;
      cfg_image[CSR_CENTER_INDEX]  = 16'd2;
      cfg_image[CSR_WINDOW_HALF]   = 16'd1;
      program_registers();

      // A tick before any scan completes must produce nothing.
      send_beat(OP_TICK, NO_RETURN, 1'b1);

      // Zero range on the right makes the obstacle near; no-return on the left
      // leaves no closer side. Walk forward -> back -> turn (no rotation) -> forward.
      ranges = {16'd100, 16'd0, 16'd7, NO_RETURN};
      send_samples(ranges);
      send_ticks(5);

      // Left sum smaller than right: turn right at full negative rate.
      ranges = {16'd0, NO_RETURN - 16'd1, 16'd5, 16'd100};
      send_samples(ranges);
      send_ticks(5);

      // Equal sums, nothing near: stay forward until the scan ages out, then stop.
      ranges = {16'd2000, 16'd2000, 16'd2000, 16'd2000};
      send_samples(ranges);
      send_ticks(5);

      // Random phases, each with fresh settings written while idle. Phases 2 and 3
      // run without any idling; phase 4 carries the over-long scan.
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         wait_drained();
         roll_config(phase == 4);
         program_registers();
         idle_pct = (phase == 2 || phase == 3) ? 0 : 6;
         run_phase(phase == 4, (phase == 4) ? 1100 : $urandom_range(60, 120));
         phase++;
      end

      wait_drained();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
